// ----- hdl/pcpe_pkg.sv -----
// ---------------------------------------------------------------------------
// pcpe_pkg: shared types and constants for the piecewise cubic evaluator
// Beat layouts, status codes, fixed-point limits and the command and status
// groups that run between the controller and the datapath.
// ---------------------------------------------------------------------------
package pcpe_pkg;

    // Input beat layout (s_tdata), lowest bit first
    localparam int SLOT_W      = 4;
    localparam int POS_W       = 32;
    localparam int COEF_W      = 48;
    localparam int SLOT_LSB    = 0;
    localparam int START_LSB   = SLOT_LSB + SLOT_W;
    localparam int CONST_LSB   = START_LSB + POS_W;
    localparam int LIN_LSB     = CONST_LSB + COEF_W;
    localparam int QUAD_LSB    = LIN_LSB + COEF_W;
    localparam int CUBIC_LSB   = QUAD_LSB + COEF_W;
    localparam int QUERY_LSB   = CUBIC_LSB + COEF_W;
    localparam int S_DATA_W    = 264;

    // Output beat layout (m_tdata)
    localparam int VALUE_W     = 32;
    localparam int M_DATA_W    = 40;
    localparam int STATUS_W    = 3;

    // Request kinds (s_tuser)
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Result status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_EVAL    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEFORE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRITTEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd4;

    // Horner step: which coefficient is added after a multiply
    localparam logic [1:0] COEF_QUAD  = 2'd0;
    localparam logic [1:0] COEF_LIN   = 2'd1;
    localparam logic [1:0] COEF_CONST = 2'd2;

    // Shared multiplier: 48-bit magnitude taken 16 bits per cycle
    localparam int DIGIT_W    = 16;
    localparam int MUL_DIGITS = 3;
    localparam int PROD_W     = 81;

    localparam logic signed [COEF_W-1:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] Q48_MIN = 48'sh8000_0000_0000;
    localparam logic signed [VALUE_W-1:0] Q32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] Q32_MIN = 32'sh8000_0000;

    // One profile record as held in the table
    typedef struct packed {
        logic signed [COEF_W-1:0] c_cubic;
        logic signed [COEF_W-1:0] c_quad;
        logic signed [COEF_W-1:0] c_lin;
        logic signed [COEF_W-1:0] c_const;
        logic signed [POS_W-1:0]  start;
    } pcpe_rec_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       mem_we;
        logic       q_load;
        logic       sel_load;
        logic       ds_calc;
        logic       mul_load;
        logic       mul_digit;
        logic       mul_round;
        logic       mul_add;
        logic [1:0] coef_sel;
        logic       fin_round;
        logic       stage_write;
        logic       stage_empty;
        logic       stage_before;
        logic       out_load;
    } pcpe_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_gt_q;
        logic out_free;
    } pcpe_sts_t;

endpackage

// ----- hdl/pcpe_ctrl.sv -----
// ---------------------------------------------------------------------------
// pcpe_ctrl: sequencer for the piecewise cubic evaluator
// Holds the record count register, runs the table scan and steps the shared
// multiplier through the three Horner products.
// ---------------------------------------------------------------------------
module pcpe_ctrl #(
    parameter int MAX_RECORDS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 req_type,
    input  logic                 cfg_wr_en,
    input  logic [4:0]           cfg_wr_data,
    input  pcpe_pkg::pcpe_sts_t  sts,
    output pcpe_pkg::pcpe_cmd_t  cmd,
    output logic [IDX_W-1:0]     rd_addr
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_DS    = 4'd2;
    localparam logic [3:0] S_MLOAD = 4'd3;
    localparam logic [3:0] S_MDIG  = 4'd4;
    localparam logic [3:0] S_MRND  = 4'd5;
    localparam logic [3:0] S_MADD  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_PUSH  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [4:0]       record_count_reg, record_count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] scan_inc;
    logic [1:0]       dig_reg, dig_next;
    logic [1:0]       step_reg, step_next;
    logic [CMP_W-1:0] rc_x;
    logic [CMP_W-1:0] max_x;
    logic [CNT_W-1:0] count;
    logic             accept;

    // effective record count, capped at the table depth
    assign rc_x  = CMP_W'(record_count_reg);
    assign max_x = CMP_W'(MAX_RECORDS);
    assign count = (rc_x > max_x) ? max_x[CNT_W-1:0] : rc_x[CNT_W-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign scan_inc = scan_reg + 1'b1;

    assign record_count_next = cfg_wr_en ? cfg_wr_data : record_count_reg;

    // next state and commands
    always_comb begin
        cmd          = '0;
        cmd.coef_sel = step_reg;
        rd_addr      = '0;
        state_next   = state_reg;
        scan_next    = scan_reg;
        dig_next     = dig_reg;
        step_next    = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.q_load = 1'b1;
                    if (req_type == pcpe_pkg::REQ_WRITE) begin
                        cmd.mem_we      = 1'b1;
                        cmd.stage_write = 1'b1;
                        state_next      = S_PUSH;
                    end else if (count == '0) begin
                        cmd.stage_empty = 1'b1;
                        state_next      = S_PUSH;
                    end else begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // table data for entry scan_reg is on the read port
                if (sts.start_gt_q) begin
                    if (scan_reg == '0) begin
                        cmd.stage_before = 1'b1;
                        state_next       = S_PUSH;
                    end else begin
                        state_next = S_DS;
                    end
                end else begin
                    cmd.sel_load = 1'b1;
                    if (scan_inc < count) begin
                        rd_addr   = scan_inc[IDX_W-1:0];
                        scan_next = scan_inc;
                    end else begin
                        state_next = S_DS;
                    end
                end
            end
            S_DS: begin
                cmd.ds_calc = 1'b1;
                step_next   = pcpe_pkg::COEF_QUAD;
                state_next  = S_MLOAD;
            end
            S_MLOAD: begin
                cmd.mul_load = 1'b1;
                dig_next     = '0;
                state_next   = S_MDIG;
            end
            S_MDIG: begin
                cmd.mul_digit = 1'b1;
                if (dig_reg == 2'(pcpe_pkg::MUL_DIGITS - 1)) begin
                    state_next = S_MRND;
                end else begin
                    dig_next = dig_reg + 1'b1;
                end
            end
            S_MRND: begin
                cmd.mul_round = 1'b1;
                state_next    = S_MADD;
            end
            S_MADD: begin
                cmd.mul_add = 1'b1;
                if (step_reg == pcpe_pkg::COEF_CONST) begin
                    state_next = S_FIN;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_MLOAD;
                end
            end
            S_FIN: begin
                cmd.fin_round = 1'b1;
                state_next    = S_PUSH;
            end
            S_PUSH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            record_count_reg <= '0;
            scan_reg         <= '0;
            dig_reg          <= '0;
            step_reg         <= pcpe_pkg::COEF_QUAD;
        end else begin
            state_reg        <= state_next;
            record_count_reg <= record_count_next;
            scan_reg         <= scan_next;
            dig_reg          <= dig_next;
            step_reg         <= step_next;
        end
    end

endmodule

// ----- hdl/pcpe_dp.sv -----
// ---------------------------------------------------------------------------
// pcpe_dp: datapath of the piecewise cubic evaluator
// Record table, selected record, offset, shared 16-bit-digit multiplier,
// rounding and saturation, result staging and the output register.
// ---------------------------------------------------------------------------
module pcpe_dp #(
    parameter int MAX_RECORDS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [pcpe_pkg::S_DATA_W-1:0]         s_tdata,
    input  pcpe_pkg::pcpe_cmd_t                   cmd,
    input  logic [IDX_W-1:0]                      rd_addr,
    output pcpe_pkg::pcpe_sts_t                   sts,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pcpe_pkg::M_DATA_W-1:0]         m_tdata,
    output logic [pcpe_pkg::STATUS_W-1:0]         m_tuser
);

    localparam int PW = pcpe_pkg::PROD_W;
    localparam int CW = pcpe_pkg::COEF_W;
    localparam int DW = pcpe_pkg::DIGIT_W;

    // input fields
    logic [pcpe_pkg::SLOT_W-1:0]      in_slot;
    logic signed [pcpe_pkg::POS_W-1:0] in_query;
    pcpe_pkg::pcpe_rec_t               in_rec;
    logic                              slot_ok;

    assign in_slot        = s_tdata[pcpe_pkg::SLOT_LSB +: pcpe_pkg::SLOT_W];
    assign in_query       = s_tdata[pcpe_pkg::QUERY_LSB +: pcpe_pkg::POS_W];
    assign in_rec.start   = s_tdata[pcpe_pkg::START_LSB +: pcpe_pkg::POS_W];
    assign in_rec.c_const = s_tdata[pcpe_pkg::CONST_LSB +: CW];
    assign in_rec.c_lin   = s_tdata[pcpe_pkg::LIN_LSB +: CW];
    assign in_rec.c_quad  = s_tdata[pcpe_pkg::QUAD_LSB +: CW];
    assign in_rec.c_cubic = s_tdata[pcpe_pkg::CUBIC_LSB +: CW];
    assign slot_ok        = (32'(in_slot) < MAX_RECORDS);

    // record table, one write and one registered read port
    pcpe_pkg::pcpe_rec_t mem [MAX_RECORDS];
    pcpe_pkg::pcpe_rec_t rd_data_reg;
    logic [IDX_W-1:0]    rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mem_we && slot_ok) begin
            mem[IDX_W'(in_slot)] <= in_rec;
        end
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    // query, selected record and evaluation registers
    logic signed [pcpe_pkg::POS_W-1:0] q_reg;
    pcpe_pkg::pcpe_rec_t               sel_reg;
    logic [IDX_W-1:0]                  sel_idx_reg;
    logic signed [pcpe_pkg::POS_W:0]   ds_reg;
    logic signed [CW-1:0]              acc_reg;
    logic [CW-1:0]                     ma_reg;
    logic [pcpe_pkg::POS_W:0]          md_reg;
    logic                              neg_reg;
    logic [PW-1:0]                     prod_reg;
    logic signed [CW-1:0]              mres_reg;
    logic                              sat_reg;

    assign sts.start_gt_q = (rd_data_reg.start > q_reg);

    // record index as a 4-bit field, whatever the table depth
    logic [IDX_W+3:0]                 k_ext;
    logic [pcpe_pkg::SLOT_W-1:0]      k4;
    assign k_ext = {4'b0, sel_idx_reg};
    assign k4    = k_ext[3:0];

    // one 16-bit digit of the accumulator magnitude times |ds|
    logic [DW+pcpe_pkg::POS_W:0] dig_prod;
    assign dig_prod = ma_reg[CW-1 -: DW] * md_reg;

    // product rounding back to Q16.32
    logic [PW-1:0]   prod_rnd;
    logic [PW-17:0]  r_mag;
    logic            r_over;
    assign prod_rnd = prod_reg + PW'(32'h8000);
    assign r_mag    = prod_rnd[PW-1:16];
    assign r_over   = neg_reg ? (r_mag > (65'd1 << 47)) : (r_mag > ((65'd1 << 47) - 65'd1));

    // coefficient for the current Horner step
    logic signed [CW-1:0] coef;
    always_comb begin
        case (cmd.coef_sel)
            pcpe_pkg::COEF_QUAD: coef = sel_reg.c_quad;
            pcpe_pkg::COEF_LIN:  coef = sel_reg.c_lin;
            default:             coef = sel_reg.c_const;
        endcase
    end

    logic [CW:0] sum49;
    logic        sum_over;
    assign sum49    = {mres_reg[CW-1], mres_reg} + {coef[CW-1], coef};
    assign sum_over = (sum49[CW] != sum49[CW-1]);

    // final rounding to Q16.16
    logic [CW-1:0]                    f_mag;
    logic [CW:0]                      f_sum;
    logic [pcpe_pkg::POS_W:0]         f_rm;
    logic                             f_over;
    logic signed [pcpe_pkg::VALUE_W-1:0] f_value;
    assign f_mag  = acc_reg[CW-1] ? CW'(-acc_reg) : CW'(acc_reg);
    assign f_sum  = {1'b0, f_mag} + 49'h8000;
    assign f_rm   = f_sum[CW:16];
    assign f_over = acc_reg[CW-1] ? (f_rm > (33'd1 << 31)) : (f_rm > ((33'd1 << 31) - 33'd1));
    always_comb begin
        if (acc_reg[CW-1]) begin
            f_value = f_over ? pcpe_pkg::Q32_MIN : 32'(-f_rm);
        end else begin
            f_value = f_over ? pcpe_pkg::Q32_MAX : f_rm[pcpe_pkg::VALUE_W-1:0];
        end
    end

    // evaluation steps
    always_ff @(posedge aclk) begin
        if (cmd.q_load) begin
            q_reg <= in_query;
        end
        if (cmd.sel_load) begin
            sel_reg     <= rd_data_reg;
            sel_idx_reg <= rd_idx_reg;
        end
        if (cmd.ds_calc) begin
            ds_reg  <= {q_reg[pcpe_pkg::POS_W-1], q_reg}
                       - {sel_reg.start[pcpe_pkg::POS_W-1], sel_reg.start};
            acc_reg <= sel_reg.c_cubic;
            sat_reg <= 1'b0;
        end
        if (cmd.mul_load) begin
            ma_reg   <= acc_reg[CW-1] ? CW'(-acc_reg) : CW'(acc_reg);
            md_reg   <= ds_reg[pcpe_pkg::POS_W] ? 33'(-ds_reg) : 33'(ds_reg);
            neg_reg  <= acc_reg[CW-1] ^ ds_reg[pcpe_pkg::POS_W];
            prod_reg <= '0;
        end
        if (cmd.mul_digit) begin
            prod_reg <= {prod_reg[PW-DW-1:0], {DW{1'b0}}} + PW'(dig_prod);
            ma_reg   <= {ma_reg[CW-DW-1:0], {DW{1'b0}}};
        end
        if (cmd.mul_round) begin
            if (r_over) begin
                mres_reg <= neg_reg ? pcpe_pkg::Q48_MIN : pcpe_pkg::Q48_MAX;
                sat_reg  <= 1'b1;
            end else begin
                mres_reg <= neg_reg ? CW'(-r_mag[CW-1:0]) : r_mag[CW-1:0];
            end
        end
        if (cmd.mul_add) begin
            if (sum_over) begin
                acc_reg <= sum49[CW] ? pcpe_pkg::Q48_MIN : pcpe_pkg::Q48_MAX;
                sat_reg <= 1'b1;
            end else begin
                acc_reg <= sum49[CW-1:0];
            end
        end
    end

    // result staging
    logic signed [pcpe_pkg::VALUE_W-1:0] stg_value_reg;
    logic [pcpe_pkg::SLOT_W-1:0]         stg_idx_reg;
    logic [pcpe_pkg::STATUS_W-1:0]       stg_status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.stage_write) begin
            stg_value_reg  <= '0;
            stg_idx_reg    <= in_slot;
            stg_status_reg <= pcpe_pkg::ST_WRITTEN;
        end else if (cmd.stage_empty) begin
            stg_value_reg  <= '0;
            stg_idx_reg    <= '0;
            stg_status_reg <= pcpe_pkg::ST_EMPTY;
        end else if (cmd.stage_before) begin
            stg_value_reg  <= '0;
            stg_idx_reg    <= '0;
            stg_status_reg <= pcpe_pkg::ST_BEFORE;
        end else if (cmd.fin_round) begin
            stg_value_reg  <= f_value;
            stg_idx_reg    <= k4;
            stg_status_reg <= (sat_reg || f_over) ? pcpe_pkg::ST_SAT : pcpe_pkg::ST_EVAL;
        end
    end

    // output register
    logic                                out_valid_reg;
    logic signed [pcpe_pkg::VALUE_W-1:0] out_value_reg;
    logic [pcpe_pkg::SLOT_W-1:0]         out_idx_reg;
    logic [pcpe_pkg::STATUS_W-1:0]       out_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg  <= stg_value_reg;
            out_idx_reg    <= stg_idx_reg;
            out_status_reg <= stg_status_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {4'b0, out_idx_reg, out_value_reg};
    assign m_tuser      = out_status_reg;

endmodule

// ----- hdl/piecewise_cubic_profile_evaluator_unit.sv -----
// ---------------------------------------------------------------------------
// piecewise_cubic_profile_evaluator_unit: piecewise cubic profile evaluator
// Table of cubic records loaded by write beats; query beats evaluate the
// profile at a Q16.16 position with a rounded, saturating Horner scheme.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser selects a record write or a query. A write
//   stores the record in the slot given and returns status "written". A query
//   scans the first record_count records (set through cfg_wr_en/cfg_wr_data
//   while idle) and evaluates the chosen record's cubic.
//   Result beats on m_*: one per input beat, in order.
// Sequencing:
//   One beat is in work at a time. A write or an empty-table query is staged
//   when accepted and then loaded into the output register; a query before
//   the first record passes the scan state first. An evaluated query reads
//   table entries (one per cycle, at most the capped record count), then runs
//   an offset step, three Horner products (each a load, three digit steps of
//   the single 16x33 multiplier, a round and an add), a final rounding step
//   and the output load.
// Reset: aresetn clears record_count to 0 and empties the output register.
//   The record table is not cleared; a slot reads undefined until written.
// Stall: a result waits in the output register while m_tready is low; the
//   next result then waits in staging with s_tready low, and the next input
//   beat is taken as soon as the sequencer is back in idle.
// ---------------------------------------------------------------------------
module piecewise_cubic_profile_evaluator_unit #(
    parameter int MAX_RECORDS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config: record_count
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] record_index, [35:4] start_pos, [83:36] coef_const,
    // [131:84] coef_lin, [179:132] coef_quad, [227:180] coef_cubic,
    // [259:228] query_pos, [263:260] zero
    input  logic [263:0] s_tdata,
    // [0] req_type
    input  logic [0:0]   s_tuser,
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] value, [35:32] record_used, [39:36] zero
    output logic [39:0]  m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser
);

    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    pcpe_pkg::pcpe_cmd_t cmd;
    pcpe_pkg::pcpe_sts_t sts;
    logic [IDX_W-1:0]    rd_addr;

    pcpe_ctrl #(
        .MAX_RECORDS (MAX_RECORDS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser[0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sts         (sts),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    pcpe_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .IDX_W       (IDX_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // table written only on an accepted write beat
    a_mem_we_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_we |-> (s_tvalid && s_tready && s_tuser[0] == pcpe_pkg::REQ_WRITE))
        else $error("table write without an accepted write beat");

    // one multiplier step at a time
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mul_load, cmd.mul_digit, cmd.mul_round, cmd.mul_add, cmd.fin_round}))
        else $error("overlapping evaluation steps");

    // a loaded result shows up on the output
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("result load lost");

    // no input taken while a result is being pushed out
    a_no_accept_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !s_tready)
        else $error("input accepted during result push");

    // results that were not evaluated carry a zero value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == pcpe_pkg::ST_EMPTY || m_tuser == pcpe_pkg::ST_BEFORE
                      || m_tuser == pcpe_pkg::ST_WRITTEN)) |-> (m_tdata[31:0] == 32'd0))
        else $error("nonzero value on a result that was not evaluated");

endmodule

// ----- sim/tb_piecewise_cubic_profile_evaluator_unit.sv -----
// ---------------------------------------------------------------------------
// tb_piecewise_cubic_profile_evaluator_unit: self-checking bench
// Loads profile tables through write beats, sets record_count between phases
// and fires query beats at chosen positions. Every result beat is checked
// against a local predictor of the rounded, saturating Horner evaluation.
// Both stream sides are throttled at random.
// ---------------------------------------------------------------------------
module tb_piecewise_cubic_profile_evaluator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 50;

    // field widths from the package
    localparam int SLOT_W   = pcpe_pkg::SLOT_W;
    localparam int POS_W    = pcpe_pkg::POS_W;
    localparam int COEF_W   = pcpe_pkg::COEF_W;
    localparam int VALUE_W  = pcpe_pkg::VALUE_W;
    localparam int STATUS_W = pcpe_pkg::STATUS_W;
    localparam int S_DATA_W = pcpe_pkg::S_DATA_W;
    localparam int M_DATA_W = pcpe_pkg::M_DATA_W;

    // One input beat and one result beat, as the bench sees them
    typedef struct packed {
        logic                    req;
        logic [SLOT_W-1:0]       slot;
        pcpe_pkg::pcpe_rec_t     rec;
        logic signed [POS_W-1:0] query;
    } profile_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]         used;
        logic [STATUS_W-1:0]       status;
    } profile_res_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [4:0]          cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [0:0]          s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    // Predictor state
    pcpe_pkg::pcpe_rec_t profile_table [TABLE_DEPTH];
    logic [4:0]          count_setting;
    profile_res_t        pending_results [$];

    int mismatch_count;
    int cycle_count;
    int hold_request;
    bit steady_flow;

    piecewise_cubic_profile_evaluator_unit #(
        .MAX_RECORDS(TABLE_DEPTH)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL piecewise_cubic_profile_evaluator_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_q48(longint v, inout bit sat);
        if (v > longint'(pcpe_pkg::Q48_MAX)) begin
            sat = 1'b1;
            return longint'(pcpe_pkg::Q48_MAX);
        end
        if (v < longint'(pcpe_pkg::Q48_MIN)) begin
            sat = 1'b1;
            return longint'(pcpe_pkg::Q48_MIN);
        end
        return v;
    endfunction

    // Q16.32 times Q17.16, rounded half away from zero back to Q16.32
    function automatic longint scaled_product(longint acc, longint ds, inout bit sat);
        logic [95:0] ma;
        logic [95:0] md;
        logic [95:0] r;
        bit          neg;
        neg = (acc < 0) != (ds < 0);
        ma  = (acc < 0) ? 96'(-acc) : 96'(acc);
        md  = (ds < 0) ? 96'(-ds) : 96'(ds);
        r   = (ma * md + 96'h8000) >> 16;
        if (r > (neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF)) begin
            sat = 1'b1;
            return neg ? longint'(pcpe_pkg::Q48_MIN) : longint'(pcpe_pkg::Q48_MAX);
        end
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic profile_res_t predict_profile(profile_req_t item);
        profile_res_t res;
        int           rows;
        int           k;
        int           i;
        longint       q;
        longint       ds;
        longint       acc;
        longint       mag;
        longint       rm;
        bit           sat;
        res = '0;
        sat = 1'b0;
        if (item.req == pcpe_pkg::REQ_WRITE) begin
            if (item.slot < TABLE_DEPTH)
                profile_table[item.slot] = item.rec;
            res.used   = item.slot;
            res.status = pcpe_pkg::ST_WRITTEN;
            return res;
        end
        rows = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
        if (rows == 0) begin
            res.status = pcpe_pkg::ST_EMPTY;
            return res;
        end
        q = item.query;
        if (q < longint'(profile_table[0].start)) begin
            res.status = pcpe_pkg::ST_BEFORE;
            return res;
        end
        // last start not above q, stopping at the first one above it
        k = 0;
        for (i = 1; i < rows; i++) begin
            if (longint'(profile_table[i].start) <= q)
                k = i;
            else
                break;
        end
        ds  = q - longint'(profile_table[k].start);
        acc = profile_table[k].c_cubic;
        acc = clamp_q48(scaled_product(acc, ds, sat) + profile_table[k].c_quad, sat);
        acc = clamp_q48(scaled_product(acc, ds, sat) + profile_table[k].c_lin, sat);
        acc = clamp_q48(scaled_product(acc, ds, sat) + profile_table[k].c_const, sat);
        // Q16.32 -> Q16.16, round then saturate
        mag = (acc < 0) ? -acc : acc;
        rm  = (mag + 64'sh8000) >>> 16;
        if (acc < 0) begin
            if (rm > 64'sh8000_0000) begin
                sat = 1'b1;
                rm  = 64'sh8000_0000;
            end
            res.value = VALUE_W'(-rm);
        end else begin
            if (rm > 64'sh7FFF_FFFF) begin
                sat = 1'b1;
                rm  = 64'sh7FFF_FFFF;
            end
            res.value = VALUE_W'(rm);
        end
        res.used   = SLOT_W'(k);
        res.status = sat ? pcpe_pkg::ST_SAT : pcpe_pkg::ST_EVAL;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic longint rand_signed(int w);
        longint v;
        if (w <= 0)
            return 0;
        v = longint'({$urandom, $urandom});
        v = v << (64 - w);
        return v >>> (64 - w);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return POS_W'(v);
    endfunction

    // mostly moderate magnitudes, sometimes anything up to full width
    function automatic logic signed [COEF_W-1:0] rand_coef();
        if ($urandom_range(3) == 0)
            return COEF_W'(rand_signed($urandom_range(48)));
        return COEF_W'(rand_signed($urandom_range(12, 34)));
    endfunction

    function automatic pcpe_pkg::pcpe_rec_t random_record(logic signed [POS_W-1:0] start);
        pcpe_pkg::pcpe_rec_t rec;
        rec.start   = start;
        rec.c_const = rand_coef();
        rec.c_lin   = rand_coef();
        rec.c_quad  = rand_coef();
        rec.c_cubic = rand_coef();
        return rec;
    endfunction

    function automatic pcpe_pkg::pcpe_rec_t make_record(logic signed [POS_W-1:0] start,
                                                        logic signed [COEF_W-1:0] a,
                                                        logic signed [COEF_W-1:0] b,
                                                        logic signed [COEF_W-1:0] c,
                                                        logic signed [COEF_W-1:0] d);
        pcpe_pkg::pcpe_rec_t rec;
        rec.start   = start;
        rec.c_const = a;
        rec.c_lin   = b;
        rec.c_quad  = c;
        rec.c_cubic = d;
        return rec;
    endfunction

    // Query position near the loaded records, on a start, or anywhere
    function automatic logic signed [POS_W-1:0] pick_query_pos(int rows);
        longint      lo;
        longint      hi;
        longint      span;
        longint      q;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            q = profile_table[$urandom_range(rows - 1)].start;
        end else if (pick < 80) begin
            lo = profile_table[0].start;
            hi = profile_table[rows - 1].start;
            if (hi < lo)
                hi = lo;
            span = hi - lo + 65536;
            lo   = lo - span / 8;
            hi   = hi + span / 4;
            q    = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
        end else begin
            q = rand_signed(POS_W);
        end
        return clamp_pos(q);
    endfunction

    function automatic int active_rows();
        return (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_setting);
    endfunction

    // ------------------------------------------------------------------
    // Beat driver and configuration
    // ------------------------------------------------------------------

    task automatic send_request(profile_req_t item);
        profile_res_t expected;
        @(negedge aclk);
        if (!steady_flow && $urandom_range(99) < 15) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = item.req;
        s_tdata  = {4'b0, item.query, item.rec.c_cubic, item.rec.c_quad,
                    item.rec.c_lin, item.rec.c_const, item.rec.start, item.slot};
        do @(posedge aclk); while (!s_tready);
        expected        = predict_profile(item);
        pending_results = {pending_results, expected};
    endtask

    task automatic send_write(logic [SLOT_W-1:0] slot, pcpe_pkg::pcpe_rec_t rec);
        profile_req_t item;
        item.req   = pcpe_pkg::REQ_WRITE;
        item.slot  = slot;
        item.rec   = rec;
        item.query = POS_W'(rand_signed(POS_W));
        send_request(item);
    endtask

    // unused record fields carry random junk
    task automatic send_query(logic signed [POS_W-1:0] q);
        profile_req_t item;
        item.req   = pcpe_pkg::REQ_QUERY;
        item.slot  = SLOT_W'($urandom_range(15));
        item.rec   = random_record(POS_W'(rand_signed(POS_W)));
        item.query = q;
        send_request(item);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_record_count(logic [4:0] count);
        wait_for_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = count;
        @(negedge aclk);
        cfg_wr_en     = 1'b0;
        count_setting = count;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // record_count is zero out of reset
    task automatic test_empty_table();
        send_query(32'sh8000_0000);
        send_query(32'sh7FFF_FFFF);
        send_query(POS_W'(rand_signed(POS_W)));
    endtask

    // before first record, exact start, stop at first larger start, saturation
    task automatic test_basic_queries();
        send_write(4'd0, make_record(32'sh0000_0000, 48'sh0001_0000_0000,
                                     48'sh0000_8000_0000, 48'sh0, 48'sh0000_0010_0000));
        // half-LSB negative constant: rounds away from zero
        send_write(4'd1, make_record(32'sh000A_0000, 48'shFFFF_FFFF_8000, 48'sh0, 48'sh0,
                                     48'sh0));
        send_write(4'd2, make_record(32'sh0014_0000, pcpe_pkg::Q48_MAX, pcpe_pkg::Q48_MAX,
                                     pcpe_pkg::Q48_MAX, pcpe_pkg::Q48_MAX));
        // out of order start, only reached when the scan gets past slot 2
        send_write(4'd3, make_record(32'sh0005_0000, 48'sh0003_0000_0000,
                                     48'shFFFF_0000_0000, 48'sh0000_1000_0000,
                                     48'shFFFF_FF00_0000));
        set_record_count(5'd4);
        send_query(32'shFFFF_FFFF);
        send_query(32'sh0000_0000);
        send_query(32'sh0003_0000);
        send_query(32'sh000F_0000);
        send_query(32'sh0019_0000);
        send_query(32'sh7FFF_FFFF);
    endtask

    // extreme starts and coefficients
    task automatic test_range_extremes();
        send_write(4'd0, make_record(32'sh8000_0000, pcpe_pkg::Q48_MIN, pcpe_pkg::Q48_MIN,
                                     pcpe_pkg::Q48_MIN, pcpe_pkg::Q48_MIN));
        send_write(4'd4, make_record(32'sh7FFF_FFFF, pcpe_pkg::Q48_MAX, 48'sh0, 48'sh0,
                                     48'sh0));
        set_record_count(5'd5);
        send_query(32'sh8000_0000);
        send_query(32'sh7FFF_FFFF);
        send_query(32'sh0000_0000);
    endtask

    // sorted tables with random content, queries around them, stray writes
    task automatic test_sorted_profiles();
        int          phase;
        int          rows;
        int          i;
        longint      pos;
        int unsigned step_max;
        for (phase = 0; phase < 7; phase++) begin
            rows     = (phase == 0 || phase == 6) ? TABLE_DEPTH : $urandom_range(1, TABLE_DEPTH);
            pos      = rand_signed($urandom_range(8, 31));
            step_max = 1 << $urandom_range(4, 22);
            for (i = 0; i < rows; i++) begin
                // now and then two records share a start
                if (i > 0 && $urandom_range(15) != 0)
                    pos = clamp_pos(pos + $urandom_range(1, step_max));
                send_write(SLOT_W'(i), random_record(clamp_pos(pos)));
            end
            if (phase == 0)
                set_record_count(5'd16);
            else if (phase == 1)
                set_record_count(5'd1);
            else
                set_record_count(5'($urandom_range(1, rows)));
            repeat (36) begin
                if ($urandom_range(99) < 8)
                    send_write(SLOT_W'($urandom_range(15)),
                               random_record(POS_W'(rand_signed(POS_W))));
                else
                    send_query(pick_query_pos(active_rows()));
            end
        end
    endtask

    // counts above the table depth use the whole table; zero empties it
    task automatic test_count_clamp();
        set_record_count(5'd20);
        repeat (25) send_query(pick_query_pos(TABLE_DEPTH));
        set_record_count(5'd0);
        send_query(pick_query_pos(TABLE_DEPTH));
        send_query(POS_W'(rand_signed(POS_W)));
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_stall();
        set_record_count(5'd16);
        hold_request = 300;
        repeat (12) begin
            if ($urandom_range(3) == 0)
                send_write(SLOT_W'($urandom_range(15)), random_record(pick_query_pos(16)));
            else
                send_query(pick_query_pos(active_rows()));
        end
        wait_for_results();
    endtask

    // back to back beats with both sides always ready
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        repeat (40) begin
            if ($urandom_range(4) == 0)
                send_write(SLOT_W'($urandom_range(15)), random_record(pick_query_pos(16)));
            else
                send_query(pick_query_pos(active_rows()));
        end
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    // anything goes, with the top count value
    task automatic test_mixed_noise();
        set_record_count(5'd31);
        repeat (50) begin
            if ($urandom_range(99) < 40)
                send_write(SLOT_W'($urandom_range(15)),
                           random_record(POS_W'(rand_signed(POS_W))));
            else if ($urandom_range(1) == 0)
                send_query(pick_query_pos(active_rows()));
            else
                send_query(POS_W'(rand_signed(POS_W)));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else if (steady_flow) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(99) >= 15);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        profile_res_t want;
        profile_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.value  = m_tdata[VALUE_W-1:0];
            got.used   = m_tdata[VALUE_W+SLOT_W-1:VALUE_W];
            got.status = m_tuser;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, value %h used %0d status %0d",
                         $time, got.value, got.used, got.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: value mismatch, expected %h, got %h",
                             $time, want.value, got.value);
                    mismatch_count++;
                end
                if (got.used !== want.used) begin
                    $display("%0t: record_used mismatch, expected %0d, got %0d",
                             $time, want.used, got.used);
                    mismatch_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        count_setting  = '0;
        mismatch_count = 0;
        hold_request   = 0;
        steady_flow    = 1'b0;
        foreach (profile_table[i])
            profile_table[i] = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_table();
        test_basic_queries();
        test_range_extremes();
        test_sorted_profiles();
        test_count_clamp();
        test_output_stall();
        test_steady_flow();
        test_mixed_noise();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS piecewise_cubic_profile_evaluator_unit");
        else
            $display("FAIL piecewise_cubic_profile_evaluator_unit");
        $finish;
    end

endmodule
